[src/slcd_pkg.sv]
// Shared types, codes and constants for the segment LCD RAM writer.
// No dependencies; used by slcd_ctrl, slcd_datapath and segment_lcd_ram_writer.
`default_nettype none

package slcd_pkg;

    localparam int DEFAULT_RAM_DEPTH = 32;
    localparam int MAX_FRAMES        = 32;

    localparam logic [2:0] CMD_STORE = 3'd0;
    localparam logic [2:0] CMD_SEND  = 3'd1;
    localparam logic [2:0] CMD_FLUSH = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_FILL  = 3'd4;

    localparam logic [1:0] MODE_REPLACE = 2'd0;
    localparam logic [1:0] MODE_SET     = 2'd1;
    localparam logic [1:0] MODE_CLR     = 2'd2;

    localparam logic [2:0] HDR_CMD  = 3'b100;
    localparam logic [2:0] HDR_DATA = 3'b101;
    localparam logic [3:0] LEN_CMD  = 4'd12;
    localparam logic [3:0] LEN_DATA = 4'd13;

    localparam logic [3:0] NIBBLE_ZERO = 4'h0;
    localparam logic [3:0] NIBBLE_ONES = 4'hF;

    typedef struct packed {
        logic item_load;
        logic rd_item;
        logic rd_cnt;
        logic cnt_clr;
        logic ram_write;
        logic ram_clear;
        logic ram_fill;
        logic out_cmd;
        logic out_flush;
    } dp_cmd_t;

    typedef struct packed {
        logic addr_ok;
        logic cnt_done;
        logic rd_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [3:0] reverse_nibble(input logic [3:0] n);
        return {n[0], n[1], n[2], n[3]};
    endfunction

endpackage

`default_nettype wire

[src/slcd_datapath.sv]
// Datapath: shadow RAM with valid bits and base value, flush counter, output register.
// Depends on slcd_pkg.
`default_nettype none

module slcd_datapath #(
    parameter int RAM_DEPTH = slcd_pkg::DEFAULT_RAM_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire slcd_pkg::dp_cmd_t    cmd,
    output slcd_pkg::dp_status_t      status,
    input  wire logic [1:0]           write_mode,
    input  wire logic [5:0]           address,
    input  wire logic [3:0]           data_nibble,
    input  wire logic [7:0]           command_code,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,
    output logic [3:0]                m_tuser,
    output logic                      m_tlast
);

    localparam int AW      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int FLUSH_N = (RAM_DEPTH < slcd_pkg::MAX_FRAMES) ? RAM_DEPTH
                                                                 : slcd_pkg::MAX_FRAMES;
    localparam int CW      = $clog2(FLUSH_N + 1);

    logic [3:0]           mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] valid_reg;
    logic [3:0]           base_reg;
    logic [3:0]           rd_q_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [CW-1:0]        cnt_reg;
    logic [AW-1:0]        item_addr_reg;
    logic [1:0]           item_mode_reg;
    logic [3:0]           item_nib_reg;
    logic                 out_valid_reg;
    logic [12:0]          out_bits_reg;
    logic [3:0]           out_len_reg;
    logic                 out_last_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [3:0]    eff_data;
    logic [3:0]    wr_data;
    logic          out_load;

    assign rd_en    = cmd.rd_item | cmd.rd_cnt;
    assign rd_addr  = cmd.rd_item ? address[AW-1:0] : AW'(cnt_reg);
    assign eff_data = valid_reg[rd_idx_reg] ? rd_q_reg : base_reg;
    assign out_load = cmd.out_cmd | cmd.out_flush;

    always_comb
    begin
        unique case (item_mode_reg)
            slcd_pkg::MODE_REPLACE: wr_data = item_nib_reg;
            slcd_pkg::MODE_SET:     wr_data = eff_data | item_nib_reg;
            slcd_pkg::MODE_CLR:     wr_data = eff_data & ~item_nib_reg;
            default:                wr_data = eff_data;
        endcase
    end

    assign status.addr_ok  = {1'b0, address} < 7'(RAM_DEPTH);
    assign status.cnt_done = cnt_reg == CW'(FLUSH_N);
    assign status.rd_last  = rd_idx_reg == AW'(FLUSH_N - 1);
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg   <= mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
        if (cmd.ram_write)
        begin
            mem[item_addr_reg] <= wr_data;
        end
        if (cmd.item_load)
        begin
            item_addr_reg <= address[AW-1:0];
            item_mode_reg <= write_mode;
            item_nib_reg  <= data_nibble;
        end
        if (cmd.out_cmd)
        begin
            out_bits_reg <= {1'b0, slcd_pkg::HDR_CMD, command_code, 1'b0};
            out_len_reg  <= slcd_pkg::LEN_CMD;
            out_last_reg <= 1'b1;
        end
        else if (cmd.out_flush)
        begin
            out_bits_reg <= {slcd_pkg::HDR_DATA, 6'(rd_idx_reg),
                             slcd_pkg::reverse_nibble(eff_data)};
            out_len_reg  <= slcd_pkg::LEN_DATA;
            out_last_reg <= status.rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            base_reg      <= slcd_pkg::NIBBLE_ZERO;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ram_clear || cmd.ram_fill)
            begin
                valid_reg <= '0;
                base_reg  <= cmd.ram_fill ? slcd_pkg::NIBBLE_ONES : slcd_pkg::NIBBLE_ZERO;
            end
            else if (cmd.ram_write)
            begin
                valid_reg[item_addr_reg] <= 1'b1;
            end
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.rd_cnt)
                cnt_reg <= cnt_reg + CW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_bits_reg};
    assign m_tuser  = out_len_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> status.out_free)
        else $error("output register overwritten while holding a transfer");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_cnt |-> !status.cnt_done)
        else $error("flush read past last entry");
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_write |-> $past(cmd.rd_item))
        else $error("store write without preceding read");
    a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ram_clear || cmd.ram_fill) |=> (valid_reg == '0))
        else $error("valid bits not cleared by clear or fill");
`endif

endmodule

`default_nettype wire

[src/slcd_ctrl.sv]
// Controller state machine: decodes commands, sequences store and flush.
// Depends on slcd_pkg.
`default_nettype none

module slcd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2:0]           command,
    input  wire logic                 flush_after,
    input  wire slcd_pkg::dp_status_t status,
    output slcd_pkg::dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        IDLE,
        STORE_WR,
        FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   accept;

    assign s_tready = (state_reg == IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                pend_next = 1'b0;
                if (accept)
                begin
                    unique case (command)
                        slcd_pkg::CMD_STORE:
                        begin
                            cmd.item_load = 1'b1;
                            if (status.addr_ok)
                            begin
                                cmd.rd_item = 1'b1;
                                state_next  = STORE_WR;
                            end
                        end
                        slcd_pkg::CMD_SEND:
                            cmd.out_cmd = 1'b1;
                        slcd_pkg::CMD_FLUSH:
                        begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = FLUSH;
                        end
                        slcd_pkg::CMD_CLEAR, slcd_pkg::CMD_FILL:
                        begin
                            cmd.ram_clear = (command == slcd_pkg::CMD_CLEAR);
                            cmd.ram_fill  = (command == slcd_pkg::CMD_FILL);
                            if (flush_after)
                            begin
                                cmd.cnt_clr = 1'b1;
                                state_next  = FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            STORE_WR:
            begin
                cmd.ram_write = 1'b1;
                state_next    = IDLE;
            end
            FLUSH:
            begin
                cmd.out_flush = pend_reg && status.out_free;
                cmd.rd_cnt    = !status.cnt_done && (!pend_reg || cmd.out_flush);
                if (cmd.rd_cnt)
                    pend_next = 1'b1;
                else if (cmd.out_flush)
                    pend_next = 1'b0;
                if (cmd.out_flush && status.rd_last)
                    state_next = IDLE;
            end
            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

`ifndef SYNTH
    a_store_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == STORE_WR) |=> (state_reg == IDLE))
        else $error("store write-back did not return to idle");
    a_flush_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FLUSH && state_next == IDLE) |-> (cmd.out_flush && !pend_next))
        else $error("flush left with a frame pending");
`endif

endmodule

`default_nettype wire

[src/segment_lcd_ram_writer.sv]
// Segment LCD RAM writer: shadow display RAM and serial frame generator.
// Store reads then writes back on the single RAM port; an address past the RAM skips
// both. A flush, or clear/fill with flush, emits N = min(RAM_DEPTH, 32) frames at one per
// cycle while m_tready is high, paced by the single registered RAM read port and by
// m_tready. No clearing pass after reset.
// Depends on slcd_pkg, slcd_ctrl, slcd_datapath.
`default_nettype none

module segment_lcd_ram_writer #(
    parameter int RAM_DEPTH = slcd_pkg::DEFAULT_RAM_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // write_mode[1:0], address[7:2], data_nibble[11:8],
                                        // command_code[19:12], flush_after[20], zero[23:21]
    input  wire logic [2:0]  s_tuser,   // command[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // frame_bits[12:0], zero[15:13]
    output logic [3:0]       m_tuser,   // frame_length[3:0]
    output logic             m_tlast    // last_frame
);

    slcd_pkg::dp_cmd_t    cmd;
    slcd_pkg::dp_status_t status;

    slcd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .command     (s_tuser),
        .flush_after (s_tdata[20]),
        .status      (status),
        .cmd         (cmd)
    );

    slcd_datapath #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .write_mode   (s_tdata[1:0]),
        .address      (s_tdata[7:2]),
        .data_nibble  (s_tdata[11:8]),
        .command_code (s_tdata[19:12]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

[test/segment_lcd_ram_writer_test.sv]
// Self-checking testbench for segment_lcd_ram_writer: random and directed commands in,
// serial LCD frames out, checked against a shadow RAM predictor kept in a small class.
// Depends on slcd_pkg and the segment_lcd_ram_writer RTL.
module segment_lcd_ram_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAM_ENTRIES  = slcd_pkg::DEFAULT_RAM_DEPTH;
    localparam int FLUSH_FRAMES = (RAM_ENTRIES < slcd_pkg::MAX_FRAMES) ? RAM_ENTRIES
                                                                       : slcd_pkg::MAX_FRAMES;
    localparam int RANDOM_ITEMS = 260;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AT_FRAME = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 2 * FLUSH_FRAMES + 8;

    // codes the block has to ignore
    localparam logic [1:0] MODE_UNUSED      = 2'd3;
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [1:0] write_mode;
        logic [5:0] address;
        logic [3:0] data_nibble;
        logic [7:0] command_code;
        logic       flush_after;
    } lcd_item_t;

    typedef struct packed {
        logic [12:0] frame_bits;
        logic [3:0]  frame_length;
        logic        last_frame;
    } lcd_frame_t;

    class lcd_frame_tracker;
        logic [3:0] shadow_ram [RAM_ENTRIES];
        lcd_frame_t expected_frames [$];
        int errors;

        function void clear_all();
            foreach (shadow_ram[i]) shadow_ram[i] = slcd_pkg::NIBBLE_ZERO;
            expected_frames.delete();
            errors = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void queue_flush();
            lcd_frame_t f;
            logic [3:0] wire_order;
            for (int i = 0; i < FLUSH_FRAMES; i++)
            begin
                for (int b = 0; b < 4; b++) wire_order[3 - b] = shadow_ram[i][b];
                f.frame_bits   = {slcd_pkg::HDR_DATA, 6'(i), wire_order};
                f.frame_length = slcd_pkg::LEN_DATA;
                f.last_frame   = (i == FLUSH_FRAMES - 1);
                expected_frames.push_back(f);
            end
        endfunction

        function void note_item(lcd_item_t it);
            lcd_frame_t f;
            case (it.command)
                slcd_pkg::CMD_STORE:
                begin
                    if (it.address < RAM_ENTRIES)
                    begin
                        case (it.write_mode)
                            slcd_pkg::MODE_REPLACE:
                                shadow_ram[it.address] = it.data_nibble;
                            slcd_pkg::MODE_SET:
                                shadow_ram[it.address] |= it.data_nibble;
                            slcd_pkg::MODE_CLR:
                                shadow_ram[it.address] &= ~it.data_nibble;
                            default: ;
                        endcase
                    end
                end
                slcd_pkg::CMD_SEND:
                begin
                    f.frame_bits   = {1'b0, slcd_pkg::HDR_CMD, it.command_code, 1'b0};
                    f.frame_length = slcd_pkg::LEN_CMD;
                    f.last_frame   = 1'b1;
                    expected_frames.push_back(f);
                end
                slcd_pkg::CMD_FLUSH: queue_flush();
                slcd_pkg::CMD_CLEAR, slcd_pkg::CMD_FILL:
                begin
                    foreach (shadow_ram[i])
                        shadow_ram[i] = (it.command == slcd_pkg::CMD_FILL) ?
                                        slcd_pkg::NIBBLE_ONES : slcd_pkg::NIBBLE_ZERO;
                    if (it.flush_after) queue_flush();
                end
                default: ;
            endcase
        endfunction

        function void check_frame(lcd_frame_t got);
            lcd_frame_t want;
            if (expected_frames.size() == 0)
            begin
                errors++;
                $error("unexpected frame: bits %h length %0d last %b",
                       got.frame_bits, got.frame_length, got.last_frame);
                return;
            end
            want = expected_frames.pop_front();
            if (got.frame_bits !== want.frame_bits)
            begin
                errors++;
                $error("frame_bits: expected %h, got %h", want.frame_bits, got.frame_bits);
            end
            if (got.frame_length !== want.frame_length)
            begin
                errors++;
                $error("frame_length: expected %0d, got %0d",
                       want.frame_length, got.frame_length);
            end
            if (got.last_frame !== want.last_frame)
            begin
                errors++;
                $error("last_frame: expected %b, got %b", want.last_frame, got.last_frame);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // write_mode, address, data_nibble, command_code, flush_after, zero
    logic [2:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // frame_bits, zero
    logic [3:0]  m_tuser;   // frame_length
    logic        m_tlast;

    lcd_frame_tracker tracker;
    int  frames_seen = 0;
    int  idle_cycles = 0;
    bit  sender_calm = 1'b0;

    segment_lcd_ram_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input lcd_item_t it);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {3'b000, it.flush_after, it.command_code, it.data_nibble,
                     it.address, it.write_mode};
        do @(posedge clk); while (!s_tready);
        tracker.note_item(it);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [2:0] command, input logic [1:0] write_mode,
                               input logic [5:0] address, input logic [3:0] data_nibble,
                               input logic [7:0] command_code, input logic flush_after);
        send_item('{command, write_mode, address, data_nibble, command_code, flush_after});
    endtask

    task automatic send_random_item();
        lcd_item_t it;
        int pick;
        it.command      = slcd_pkg::CMD_STORE;
        it.write_mode   = ($urandom_range(0, 9) == 0) ? MODE_UNUSED
                                                      : 2'($urandom_range(0, 2));
        it.address      = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(RAM_ENTRIES, 63))
                                                      : 6'($urandom_range(0, RAM_ENTRIES - 1));
        it.data_nibble  = 4'($urandom);
        it.command_code = 8'($urandom);
        it.flush_after  = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)      it.command = slcd_pkg::CMD_STORE;
        else if (pick < 75) it.command = slcd_pkg::CMD_SEND;
        else if (pick < 83) it.command = slcd_pkg::CMD_FLUSH;
        else if (pick < 89) it.command = slcd_pkg::CMD_CLEAR;
        else if (pick < 95) it.command = slcd_pkg::CMD_FILL;
        else                it.command = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        send_item(it);
    endtask

    initial
    begin
        int receive_stall;
        bit receiver_calm;
        bit holdoff_done;
        receiver_calm = 1'b0;
        holdoff_done  = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            receive_stall = receiver_calm ? 0 : $urandom_range(0, 4);
            if (!holdoff_done && frames_seen >= HOLDOFF_AT_FRAME)
            begin
                receive_stall = HOLDOFF_CYCLES;
                holdoff_done  = 1'b1;
            end
            if (receive_stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (receive_stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            tracker.check_frame('{m_tdata[12:0], m_tuser, m_tlast});
            frames_seen++;
            if (frames_seen % 24 == 0)
                receiver_calm = ($urandom_range(0, 2) == 0);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = slcd_pkg::CMD_STORE;
        tracker  = new;
        tracker.clear_all();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_REPLACE, 6'd0, 4'hF, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_REPLACE, 6'd31, 4'h5, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_SET, 6'd31, 4'hA, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_CLR, 6'd31, 4'h3, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, MODE_UNUSED, 6'd31, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_REPLACE, 6'(RAM_ENTRIES), 4'hF,
                    8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_REPLACE, 6'd63, 4'hF, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_SET, 6'd1, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_SEND, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_SEND, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'hFF, 1'b0);
        send_fields(slcd_pkg::CMD_SEND, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h80, 1'b0);
        send_fields(slcd_pkg::CMD_SEND, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h01, 1'b0);
        send_fields(slcd_pkg::CMD_FLUSH, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_CLEAR, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_FLUSH, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_FILL, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_FLUSH, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_CLEAR, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b1);
        send_fields(slcd_pkg::CMD_FILL, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b1);
        send_fields(CMD_UNUSED_FIRST, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b1);
        send_fields(CMD_UNUSED_LAST, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'hFF, 1'b0);
        send_fields(slcd_pkg::CMD_STORE, slcd_pkg::MODE_CLR, 6'd7, 4'h9, 8'h00, 1'b0);
        send_fields(slcd_pkg::CMD_FLUSH, slcd_pkg::MODE_REPLACE, 6'd0, 4'h0, 8'h00, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 20 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            send_random_item();
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
